/* rtl/core/mexp_pkg.sv */
// Shared constants for the modular exponentiation block.
// No dependencies; imported by the top level and the residue checker.
`default_nettype none

package mexp_pkg;

  // Modulus loaded at reset, truncated to the datapath width where it is used.
  localparam int unsigned MODULUS_RESET = 85;

endpackage : mexp_pkg

`default_nettype wire

/* rtl/core/mexp_mulmod.sv */
// Bit-serial modular multiplier: acc = x * y mod m, one bit of y per cycle.
// Depends on nothing else; instantiated by modular_exponentiation_top.
`default_nettype none

module mexp_mulmod #(
  parameter int WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  input  wire logic [WIDTH-1:0] m,
  output logic                  done,
  output logic [WIDTH-1:0]      result
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;

  // One double-and-add step. The sum stays below 3m, so a pair of parallel
  // compares against m and 2m picks the single subtraction needed.
  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH+1:0] step;

  always_comb begin
    m1   = {2'b00, m};
    m2   = {1'b0, m, 1'b0};
    sum  = {1'b0, acc_r, 1'b0} + (y_r[WIDTH-1] ? {2'b00, x_r} : '0);
    if (sum >= m2) begin
      step = sum - m2;
    end else if (sum >= m1) begin
      step = sum - m1;
    end else begin
      step = sum;
    end
  end

  // Operand capture and iteration control.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH);
      acc_nxt  = '0;
      x_nxt    = x;
      y_nxt    = y;
    end else if (busy_r) begin
      acc_nxt = step[WIDTH-1:0];
      y_nxt   = {y_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule : mexp_mulmod

`default_nettype wire

/* rtl/core/modular_exponentiation_top.sv */
// Modular exponentiation top level: residue = base ^ exponent mod modulus.
// Depends on mexp_pkg and mexp_mulmod.
//
//   Channel | Direction | Handshake             | Payload
//   in_     | input     | in_tvalid/in_tready   | base, exponent
//   out_    | output    | out_tvalid/out_tready | residue
//   cfg_    | input     | cfg_we                | modulus
//
// A result is presented after the bit-serial multiplier has run once to
// reduce the base, once per exponent bit to square, and once more for each
// set exponent bit. A zero modulus bypasses the multiplier and gives zero.
// One item is in work at a time; the next is taken while a result waits.
// Reset is synchronous, active low; it loads the modulus with 85.
// A stalled result holds in the output register until out_tready.
`default_nettype none

module modular_exponentiation_top #(
  parameter int WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Configuration port
  input  wire logic                                 cfg_we,
  input  wire logic [WIDTH-1:0]                     cfg_wdata,  // modulus
  // Input channel
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [((2*WIDTH+7)/8)*8-1:0]         in_tdata,   // base, exponent
  // Result channel
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [((WIDTH+7)/8)*8-1:0]                out_tdata   // residue
);

  import mexp_pkg::*;

  localparam int OUT_TDATA_W = ((WIDTH + 7) / 8) * 8;
  localparam int CNT_W       = $clog2(WIDTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [WIDTH-1:0] modulus_r, modulus_nxt;
  logic [WIDTH-1:0] base_r, base_nxt;
  logic [WIDTH-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0] bitcnt_r, bitcnt_nxt;
  logic [WIDTH-1:0] res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;

  logic             mul_start;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic             mul_done;
  logic [WIDTH-1:0] mul_res;
  logic [WIDTH-1:0] one_mod;

  mexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .x      (mul_x),
    .y      (mul_y),
    .m      (modulus_r),
    .done   (mul_done),
    .result (mul_res)
  );

  // 1 mod m: zero only for a modulus of one.
  assign one_mod = (modulus_r == WIDTH'(1)) ? '0 : WIDTH'(1);

  // Configuration register.
  assign modulus_nxt = cfg_we ? cfg_wdata : modulus_r;

  // Sequencer: reduce the base, then square-and-multiply from the top bit; a zero modulus goes straight to S_DONE.
  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    exp_nxt    = exp_r;
    bitcnt_nxt = bitcnt_r;
    res_nxt    = res_r;
    mul_start  = 1'b0;
    mul_x      = res_r;
    mul_y      = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          base_nxt   = in_tdata[WIDTH-1:0];
          exp_nxt    = in_tdata[2*WIDTH-1:WIDTH];
          bitcnt_nxt = CNT_W'(WIDTH);
          if (modulus_r == '0) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            // Base mod m is the product 1 * base, formed bit-serially.
            mul_start = 1'b1;
            mul_x     = WIDTH'(1);
            mul_y     = in_tdata[WIDTH-1:0];
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (mul_done) begin
          base_nxt  = mul_res;
          res_nxt   = one_mod;
          mul_start = 1'b1;
          mul_x     = one_mod;
          mul_y     = one_mod;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (mul_done) begin
          res_nxt = mul_res;
          if (exp_r[WIDTH-1]) begin
            mul_start = 1'b1;
            mul_x     = mul_res;
            mul_y     = base_r;
            state_nxt = S_MUL;
          end else begin
            exp_nxt    = {exp_r[WIDTH-2:0], 1'b0};
            bitcnt_nxt = bitcnt_r - CNT_W'(1);
            if (bitcnt_r == CNT_W'(1)) begin
              state_nxt = S_DONE;
            end else begin
              mul_start = 1'b1;
              mul_x     = mul_res;
              mul_y     = mul_res;
            end
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          res_nxt    = mul_res;
          exp_nxt    = {exp_r[WIDTH-2:0], 1'b0};
          bitcnt_nxt = bitcnt_r - CNT_W'(1);
          if (bitcnt_r == CNT_W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            mul_start = 1'b1;
            mul_x     = mul_res;
            mul_y     = mul_res;
            state_nxt = S_SQR;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: a finished residue moves in once the slot is free.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= WIDTH'(MODULUS_RESET);
      out_valid_r <= 1'b0;
      bitcnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
      bitcnt_r    <= bitcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule : modular_exponentiation_top

`default_nettype wire

/* rtl/core/mexp_checker.sv */
// Port-level checks for the modular exponentiation block.
// Depends on modular_exponentiation_top; attached to it by the bind below.
`default_nettype none

module mexp_checker #(
  parameter int WIDTH = 16
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [((WIDTH+7)/8)*8-1:0]   out_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // One item at a time: the block is busy right after an accepted transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in work");

  // A new result appears just as the block turns ready for the next item.
  a_result_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result presented while still busy");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule : mexp_checker

bind modular_exponentiation_top mexp_checker #(
  .WIDTH (WIDTH)
) u_mexp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* tb/mexp_residue_checker.sv */
`timescale 1ns / 1ps
// Checker for the modular exponentiation block: it watches the configuration,
// input and result channels, predicts each residue and compares it.
// Depends on mexp_pkg for the modulus loaded at reset.

module mexp_residue_checker
  import mexp_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [WIDTH-1:0]                 cfg_wdata,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  input  wire logic [((2*WIDTH+7)/8)*8-1:0]     in_tdata,   // base, exponent
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [((WIDTH+7)/8)*8-1:0]       out_tdata,  // residue
  output int                                    fail_count,
  output int                                    pending_count
);

  // The checker's own copy of the modulus register.
  logic [WIDTH-1:0] modulus_copy;
  // Residues predicted for accepted transactions, oldest first.
  logic [WIDTH-1:0] expected_residues[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Square-and-multiply over every exponent bit, most significant first.
  // A zero modulus yields zero without any arithmetic.
  function automatic logic [WIDTH-1:0] expected_residue(input logic [WIDTH-1:0] n,
                                                        input logic [WIDTH-1:0] b,
                                                        input logic [WIDTH-1:0] e);
    logic [2*WIDTH-1:0] acc;
    logic [2*WIDTH-1:0] reduced_base;
    if (n == '0) return '0;
    reduced_base = b % n;
    acc = (2*WIDTH)'(1) % n;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % n;
      if (e[i]) acc = (acc * reduced_base) % n;
    end
    return acc[WIDTH-1:0];
  endfunction

  // Prints one line per problem and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Results are checked before new inputs are predicted, so a stray result
  // can never consume a prediction made at the same edge.
  always @(posedge clk) begin
    logic [WIDTH-1:0] want;
    logic [WIDTH-1:0] got;
    if (!rst_n) begin
      modulus_copy = WIDTH'(MODULUS_RESET);
      expected_residues.delete();
    end else begin
      if (cfg_we) modulus_copy = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got = out_tdata[WIDTH-1:0];
        if (expected_residues.size() == 0) begin
          report_mismatch($sformatf("result transaction with none expected, residue %0d", got));
        end else begin
          want = expected_residues.pop_front();
          if (got !== want)
            report_mismatch($sformatf("residue %0d, expected %0d", got, want));
        end
      end
      if (in_tvalid && in_tready)
        expected_residues.push_back(expected_residue(modulus_copy, in_tdata[WIDTH-1:0],
                                                     in_tdata[2*WIDTH-1:WIDTH]));
    end
    pending_count = expected_residues.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the modular exponentiation block: clock, reset, stimulus and verdict.
// Depends on modular_exponentiation_top and mexp_residue_checker.

module tb_top;

  localparam int WIDTH = 16;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_we     = 1'b0;
  logic [WIDTH-1:0] cfg_wdata  = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata   = '0;   // base, exponent
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;         // residue

  int fail_count;
  int pending_count;
  int results_seen = 0;
  int next_hold_at = 30;

  modular_exponentiation_top #(.WIDTH(WIDTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mexp_residue_checker #(.WIDTH(WIDTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Idle stretches: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 600);
  endfunction

  // Bases lean toward zero, all ones and values around the modulus.
  function automatic logic [15:0] pick_base(input logic [15:0] modulus);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 3));
      3:       return modulus + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_exponent();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one transaction after a random gap and holds it until accepted.
  task automatic send_operands(input logic [15:0] base, input logic [15:0] exponent);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {exponent, base};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering and waits until every predicted residue has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_modulus(input logic [15:0] modulus);
    cfg_we    <= 1'b1;
    cfg_wdata <= modulus;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Boundary operands for the current modulus, then random ones.
  task automatic run_modulus_phase(input logic [15:0] modulus, input int count);
    send_operands(16'h0000, 16'h0000);
    send_operands(16'hFFFF, 16'hFFFF);
    send_operands(modulus, 16'd1);
    send_operands(modulus + 16'd1, 16'd3);
    repeat (count) send_operands(pick_base(modulus), pick_exponent());
  endtask

  // Stimulus: directed operands under the reset modulus, then one phase per
  // modulus setting, with the input idle whenever the modulus changes.
  initial begin
    logic [15:0] modulus_plan [8];
    logic [15:0] modulus;
    modulus_plan = '{16'hFFFF, 16'd2, 16'd1, 16'd0, 16'd3233, 16'd65521, 16'h8000, 16'd255};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero exponents, zero base, all-ones fields and bases at or above 85.
    send_operands(16'd0,     16'd0);
    send_operands(16'hFFFF,  16'd0);
    send_operands(16'd0,     16'd1);
    send_operands(16'd0,     16'hFFFF);
    send_operands(16'd1,     16'hFFFF);
    send_operands(16'hFFFF,  16'hFFFF);
    send_operands(16'd85,    16'd1);
    send_operands(16'd86,    16'd3);
    send_operands(16'd84,    16'd2);
    send_operands(16'd170,   16'd7);
    send_operands(16'd2,     16'd16);
    send_operands(16'd3,     16'h8000);
    send_operands(16'd7,     16'h0001);
    send_operands(16'd12345, 16'hAAAA);
    send_operands(16'd54321, 16'h5555);
    send_operands(16'd84,    16'hFFFF);
    repeat (44) send_operands(pick_base(16'd85), pick_exponent());

    // Fixed moduli including both ends of the range, one, zero, then random ones.
    for (int p = 0; p < 10; p++) begin
      modulus = (p < 8) ? modulus_plan[p] : 16'($urandom_range(2, 65535));
      drain_results();
      load_modulus(modulus);
      run_modulus_phase(modulus, (modulus < 16'd2) ? 21 : 66);
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) results_seen <= results_seen + 1;
  end

  // Result side: random stalls, stretches always ready, and a few long
  // hold-offs that back the block up into its input channel.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_seen >= next_hold_at) begin
        out_tready <= 1'b0;
        repeat (2500) @(posedge clk);
        next_hold_at += 250;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 300)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end

endmodule
